### rtl/core/assert_macros.svh
// Assertion macros shared by the motor sequencer RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/core/mrps_pkg.sv
// Package for the motor run/pause sequencer: beat types, codes and reset values.
// No dependencies.
package mrps_pkg;

	localparam int CHANNELS_DEF = 2;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_MODE  = 2'd1;
	localparam logic [1:0] KIND_DELAY = 2'd2;

	// run modes
	localparam logic [1:0] MODE_STOP  = 2'd0;
	localparam logic [1:0] MODE_RIGHT = 2'd1;
	localparam logic [1:0] MODE_LEFT  = 2'd2;
	localparam logic [1:0] MODE_ALT   = 2'd3;

	// configuration register indexes
	localparam int          CFG_IDX_W     = 3;
	localparam logic [2:0]  REG_RUN_TICKS = 3'd0;
	localparam logic [2:0]  REG_PAUSE_0   = 3'd1;
	localparam logic [2:0]  REG_PAUSE_1   = 3'd2;
	localparam logic [2:0]  REG_PAUSE_2   = 3'd3;
	localparam logic [2:0]  REG_PAUSE_3   = 3'd4;

	localparam logic [7:0] RUN_TICKS_RST = 8'd2;
	localparam logic [7:0] PAUSE_0_RST   = 8'd10;
	localparam logic [7:0] PAUSE_1_RST   = 8'd22;
	localparam logic [7:0] PAUSE_2_RST   = 8'd34;
	localparam logic [7:0] PAUSE_3_RST   = 8'd46;

	typedef struct packed {
		logic [1:0] mode;
		logic       channel;
	} cmd_t;

	typedef struct packed {
		logic       out_channel;
		logic       motor_on;
		logic       direction;
		logic [1:0] run_mode;
		logic [1:0] delay_index;
		logic       expired;
	} sts_t;

	// per-channel state word held in the state memory
	typedef struct packed {
		logic [1:0] cur_mode;
		logic [1:0] cur_delay;
		logic [7:0] pause_len;
		logic       running;
		logic       swinging;
		logic       swing_next;
		logic       dir_now;
		logic [7:0] period;
		logic [7:0] elapsed;
	} chan_state_t;

	localparam chan_state_t CHAN_STATE_RST = '{
		cur_mode:   MODE_STOP,
		cur_delay:  2'd0,
		pause_len:  PAUSE_0_RST,
		running:    1'b0,
		swinging:   1'b0,
		swing_next: 1'b0,
		dir_now:    1'b0,
		period:     8'd0,
		elapsed:    8'd0
	};

endpackage

### rtl/core/motor_run_pause_sequencer.sv
// Motor run/pause sequencer top level: per-channel state memory, update stage, result register.
// Depends on mrps_pkg and assert_macros.svh.
//
//   channel  | beat type     | handshake             | notes
//   cmd      | mrps_pkg::cmd_t | cmd_valid/cmd_ready | tick, mode press or delay press
//   sts      | mrps_pkg::sts_t | sts_valid/sts_ready | one status beat per cmd beat
//   cfg      | 8-bit data    | cfg_wr_en, cfg_index  | write only, no wait state
//
// One cmd beat per cycle sustained while sts is not stalled; a beat goes from cmd accept through
// the update stage registers to the sts register. The first step reads the channel word from
// the state memory (synchronous read), the second updates it, writes it back and loads the sts register.
// A write-back to the channel being read in the same cycle is forwarded into the read data.
// Reset clears all per-channel valid bits at once; an invalid entry reads as the reset state.
// A stalled sts holds the update stage and drops cmd_ready only while both are full.
`include "assert_macros.svh"

module motor_run_pause_sequencer #(
	parameter int CHANNELS = mrps_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  mrps_pkg::cmd_t                    cmd,
	output logic                              sts_valid,
	input  logic                              sts_ready,
	output mrps_pkg::sts_t                    sts,
	input  logic                              cfg_wr_en,
	input  logic [mrps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// ---------------- configuration registers ----------------
	logic [7:0] run_ticks_q;
	logic [7:0] pause_ticks_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_ticks_q      <= mrps_pkg::RUN_TICKS_RST;
			pause_ticks_q[0] <= mrps_pkg::PAUSE_0_RST;
			pause_ticks_q[1] <= mrps_pkg::PAUSE_1_RST;
			pause_ticks_q[2] <= mrps_pkg::PAUSE_2_RST;
			pause_ticks_q[3] <= mrps_pkg::PAUSE_3_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mrps_pkg::REG_RUN_TICKS: run_ticks_q      <= cfg_data;
				mrps_pkg::REG_PAUSE_0:   pause_ticks_q[0] <= cfg_data;
				mrps_pkg::REG_PAUSE_1:   pause_ticks_q[1] <= cfg_data;
				mrps_pkg::REG_PAUSE_2:   pause_ticks_q[2] <= cfg_data;
				mrps_pkg::REG_PAUSE_3:   pause_ticks_q[3] <= cfg_data;
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// ---------------- handshake / pipeline control ----------------
	logic s1_valid_q;
	logic sts_valid_q;
	logic s1_adv;
	logic accept;

	assign s1_adv    = s1_valid_q && (!sts_valid_q || sts_ready);
	assign cmd_ready = !s1_valid_q || s1_adv;
	assign accept    = cmd_valid && cmd_ready;

	// read address for the incoming beat; out-of-range channel reads entry 0, never writes
	logic          cmd_in_range;
	logic [AW-1:0] rd_addr;

	assign cmd_in_range = ({31'd0, cmd.channel} < CHANNELS);
	assign rd_addr      = cmd_in_range ? AW'(cmd.channel) : '0;

	// ---------------- state memory ----------------
	mrps_pkg::chan_state_t st_mem [CHANNELS];
	logic [CHANNELS-1:0]   vld_q;

	// update stage registers
	logic [1:0]            kind_s1;
	logic                  chan_s1;
	logic                  inr_s1;
	logic [AW-1:0]         addr_s1;
	mrps_pkg::chan_state_t rd_s1;
	logic                  rd_vld_s1;

	// write-back of the update stage
	logic                  wr_en;
	mrps_pkg::chan_state_t wr_data;
	logic                  fwd;

	assign wr_en = s1_adv && inr_s1;
	assign fwd   = wr_en && (addr_s1 == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			st_mem[addr_s1] <= wr_data;
		end
		if (accept) begin
			kind_s1 <= cmd.mode;
			chan_s1 <= cmd.channel;
			inr_s1  <= cmd_in_range;
			addr_s1 <= rd_addr;
			rd_s1   <= fwd ? wr_data : st_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (accept) begin
				rd_vld_s1 <= fwd || vld_q[rd_addr];
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- channel update ----------------
	mrps_pkg::chan_state_t cur;
	mrps_pkg::chan_state_t nxt;
	logic                  expired_s1;
	logic [8:0]            elapsed_inc;
	logic [1:0]            delay_inc;

	assign cur         = rd_vld_s1 ? rd_s1 : mrps_pkg::CHAN_STATE_RST;
	assign elapsed_inc = {1'b0, cur.elapsed} + 9'd1;
	assign delay_inc   = cur.cur_delay + 2'd1;

	always_comb begin
		nxt        = cur;
		expired_s1 = 1'b0;
		unique case (kind_s1)
			mrps_pkg::KIND_TICK: begin
				if (cur.period != 8'd0) begin
					if (elapsed_inc >= {1'b0, cur.period}) begin
						expired_s1  = 1'b1;
						nxt.elapsed = 8'd0;
						if (cur.running) begin
							// end of run: pause
							nxt.running = 1'b0;
							nxt.period  = cur.pause_len;
						end else begin
							// end of pause: next run, alternating flips direction
							if (cur.swinging) begin
								nxt.dir_now    = cur.swing_next;
								nxt.swing_next = ~cur.swing_next;
							end
							nxt.running = 1'b1;
							nxt.period  = run_ticks_q;
						end
					end else begin
						nxt.elapsed = elapsed_inc[7:0];
					end
				end
			end
			mrps_pkg::KIND_MODE: begin
				nxt.cur_mode = cur.cur_mode + 2'd1;
				case (nxt.cur_mode)
					mrps_pkg::MODE_STOP: begin
						nxt.period   = 8'd0;
						nxt.elapsed  = 8'd0;
						nxt.running  = 1'b0;
						nxt.swinging = 1'b0;
					end
					mrps_pkg::MODE_RIGHT: begin
						nxt.dir_now  = 1'b0;
						nxt.swinging = 1'b0;
						nxt.running  = 1'b1;
						nxt.period   = run_ticks_q;
						nxt.elapsed  = 8'd0;
					end
					mrps_pkg::MODE_LEFT: begin
						nxt.dir_now  = 1'b1;
						nxt.swinging = 1'b0;
						nxt.running  = 1'b1;
						nxt.period   = run_ticks_q;
						nxt.elapsed  = 8'd0;
					end
					default: begin  // alternating
						nxt.dir_now    = 1'b0;
						nxt.swinging   = 1'b1;
						nxt.swing_next = 1'b1;
						nxt.running    = 1'b1;
						nxt.period     = run_ticks_q;
						nxt.elapsed    = 8'd0;
					end
				endcase
			end
			mrps_pkg::KIND_DELAY: begin
				nxt.cur_delay = delay_inc;
				nxt.pause_len = pause_ticks_q[delay_inc];
				// paused in a running mode: new pause length takes effect now
				if (!cur.running && cur.cur_mode != mrps_pkg::MODE_STOP) begin
					nxt.period = pause_ticks_q[delay_inc];
				end
			end
			default: ;  // unused kind: no change
		endcase
	end

	assign wr_data = nxt;

	// ---------------- result register ----------------
	mrps_pkg::sts_t sts_d;
	mrps_pkg::sts_t sts_q;

	always_comb begin
		sts_d             = '0;
		sts_d.out_channel = chan_s1;
		if (inr_s1) begin
			sts_d.motor_on    = nxt.running;
			sts_d.direction   = nxt.dir_now;
			sts_d.run_mode    = nxt.cur_mode;
			sts_d.delay_index = nxt.cur_delay;
			sts_d.expired     = expired_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sts_q <= sts_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts_valid_q <= 1'b0;
		end else if (s1_adv) begin
			sts_valid_q <= 1'b1;
		end else if (sts_ready) begin
			sts_valid_q <= 1'b0;
		end
	end

	assign sts_valid = sts_valid_q;
	assign sts       = sts_q;

	// ---------------- assertions ----------------
	`ASSERT_PROP(a_full_stall, clk, arst_n, s1_valid_q && sts_valid_q && !sts_ready |-> !cmd_ready, "cmd taken while pipeline full")
	`ASSERT_PROP(a_exp_tick, clk, arst_n, s1_valid_q && expired_s1 |-> kind_s1 == mrps_pkg::KIND_TICK, "expiry on a non-tick beat")
	`ASSERT_PROP(a_on_mode, clk, arst_n, sts_valid_q && sts_q.motor_on |-> sts_q.run_mode != mrps_pkg::MODE_STOP, "motor on in stop mode")
	`ASSERT_PROP(a_wr_vld, clk, arst_n, wr_en |=> vld_q[$past(addr_s1)], "written entry not marked valid")

endmodule

### dv/tb_motor_run_pause_sequencer.sv
// Self-checking testbench for motor_run_pause_sequencer: drives tick and button beats,
// predicts every status beat in a small scoreboard class and compares field by field.
// Depends on mrps_pkg and the RTL of the block only.
module tb_motor_run_pause_sequencer;

	// cmd kind the block must ignore, returns status with expired low
	localparam logic [1:0] KIND_SPARE = 2'd3;
	// receiver hold-off in cycles, long enough to fill both pipeline stages
	localparam int HOLD_CYCLES = 40;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_ready;
	mrps_pkg::cmd_t cmd       = '0;
	logic           sts_valid;
	logic           sts_ready = 1'b0;
	mrps_pkg::sts_t sts;
	logic           cfg_wr_en = 1'b0;
	logic [2:0]     cfg_index = '0;
	logic [7:0]     cfg_data  = '0;

	// idling control shared by sender and receiver
	bit steady   = 1'b0;
	bit hold_req = 1'b0;
	int n_settings = 0;

	// Per-channel run/pause predictor plus queue of expected status beats.
	class motor_status_board;
		logic [7:0] run_len;
		logic [7:0] pause_tab [4];
		logic [1:0] sel_mode    [2];
		logic [1:0] sel_delay   [2];
		logic [7:0] pause_set   [2];
		logic       drive_on    [2];
		logic       alternating [2];
		logic       next_dir    [2];
		logic       dir         [2];
		logic [7:0] limit       [2];
		logic [7:0] count       [2];
		mrps_pkg::sts_t expected_sts [$];
		int errors;
		int n_cmds;
		int n_checked;
		int n_expired;

		function new();
			run_len      = mrps_pkg::RUN_TICKS_RST;
			pause_tab[0] = mrps_pkg::PAUSE_0_RST;
			pause_tab[1] = mrps_pkg::PAUSE_1_RST;
			pause_tab[2] = mrps_pkg::PAUSE_2_RST;
			pause_tab[3] = mrps_pkg::PAUSE_3_RST;
			for (int ch = 0; ch < 2; ch++) begin
				sel_mode[ch]    = mrps_pkg::MODE_STOP;
				sel_delay[ch]   = 2'd0;
				pause_set[ch]   = mrps_pkg::PAUSE_0_RST;
				drive_on[ch]    = 1'b0;
				alternating[ch] = 1'b0;
				next_dir[ch]    = 1'b0;
				dir[ch]         = 1'b0;
				limit[ch]       = 8'd0;
				count[ch]       = 8'd0;
			end
			errors    = 0;
			n_cmds    = 0;
			n_checked = 0;
			n_expired = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				mrps_pkg::REG_RUN_TICKS: run_len = val;
				mrps_pkg::REG_PAUSE_0:   pause_tab[0] = val;
				mrps_pkg::REG_PAUSE_1:   pause_tab[1] = val;
				mrps_pkg::REG_PAUSE_2:   pause_tab[2] = val;
				mrps_pkg::REG_PAUSE_3:   pause_tab[3] = val;
				default: ;
			endcase
		endfunction

		// run_ticks is sampled each time a run begins
		function void begin_run(int ch);
			drive_on[ch] = 1'b1;
			limit[ch]    = run_len;
			count[ch]    = 8'd0;
		endfunction

		function int waiting();
			return expected_sts.size();
		endfunction

		// apply one accepted cmd beat and queue the status it must produce
		function void predict_status(mrps_pkg::cmd_t c);
			mrps_pkg::sts_t want;
			int   ch;
			int   nxt;
			logic fired;
			ch    = c.channel;
			fired = 1'b0;
			n_cmds++;
			case (c.mode)
				mrps_pkg::KIND_TICK: begin
					// limit zero means the interval timer is off
					if (limit[ch] != 8'd0) begin
						nxt = int'(count[ch]) + 1;
						if (nxt >= int'(limit[ch])) begin
							fired = 1'b1;
							if (drive_on[ch]) begin
								drive_on[ch] = 1'b0;
								limit[ch]    = pause_set[ch];
								count[ch]    = 8'd0;
							end else begin
								if (alternating[ch]) begin
									dir[ch]      = next_dir[ch];
									next_dir[ch] = ~next_dir[ch];
								end
								begin_run(ch);
							end
						end else begin
							count[ch] = nxt[7:0];
						end
					end
				end
				mrps_pkg::KIND_MODE: begin
					sel_mode[ch] = sel_mode[ch] + 2'd1;
					case (sel_mode[ch])
						mrps_pkg::MODE_STOP: begin
							// direction is left where it was
							limit[ch]       = 8'd0;
							count[ch]       = 8'd0;
							drive_on[ch]    = 1'b0;
							alternating[ch] = 1'b0;
						end
						mrps_pkg::MODE_RIGHT: begin
							dir[ch]         = 1'b0;
							alternating[ch] = 1'b0;
							begin_run(ch);
						end
						mrps_pkg::MODE_LEFT: begin
							dir[ch]         = 1'b1;
							alternating[ch] = 1'b0;
							begin_run(ch);
						end
						default: begin
							dir[ch]         = 1'b0;
							alternating[ch] = 1'b1;
							next_dir[ch]    = 1'b1;
							begin_run(ch);
						end
					endcase
				end
				mrps_pkg::KIND_DELAY: begin
					sel_delay[ch] = sel_delay[ch] + 2'd1;
					pause_set[ch] = pause_tab[sel_delay[ch]];
					// a pause in progress takes the new length, count is kept
					if (!drive_on[ch] && sel_mode[ch] != mrps_pkg::MODE_STOP)
						limit[ch] = pause_set[ch];
				end
				default: ;
			endcase
			want.out_channel = c.channel;
			want.motor_on    = drive_on[ch];
			want.direction   = dir[ch];
			want.run_mode    = sel_mode[ch];
			want.delay_index = sel_delay[ch];
			want.expired     = fired;
			expected_sts.push_back(want);
		endfunction

		function void match_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_status(mrps_pkg::sts_t got);
			mrps_pkg::sts_t want;
			if (expected_sts.size() == 0) begin
				$error("status beat with nothing expected: %p", got);
				errors++;
				return;
			end
			want = expected_sts.pop_front();
			n_checked++;
			if (want.expired)
				n_expired++;
			match_field("out_channel", 2'(want.out_channel), 2'(got.out_channel));
			match_field("motor_on", 2'(want.motor_on), 2'(got.motor_on));
			match_field("direction", 2'(want.direction), 2'(got.direction));
			match_field("run_mode", want.run_mode, got.run_mode);
			match_field("delay_index", want.delay_index, got.delay_index);
			match_field("expired", 2'(want.expired), 2'(got.expired));
		endfunction
	endclass

	motor_status_board board = new();

	motor_run_pause_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.sts_valid (sts_valid),
		.sts_ready (sts_ready),
		.sts       (sts),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every TB-driven signal changes by NBA at the edge, and the DUT updates by NBA too,
	// so reading here sees the values from just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				board.predict_status(cmd);
			if (sts_valid && sts_ready)
				board.check_status(sts);
		end
	end

	// Status sink: random back-pressure, none during the steady stretch, and one long
	// hold-off on request so the pipeline backs up into cmd_ready.
	initial begin : sts_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				sts_ready <= 1'b0;
			end else begin
				sts_ready <= steady || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	// Offer one cmd beat and return at the edge where it is taken. Valid stays high into
	// the next beat unless a one-cycle gap is inserted first.
	task automatic send_cmd(input logic [1:0] kind, input logic ch);
		mrps_pkg::cmd_t c;
		c.mode    = kind;
		c.channel = ch;
		if (!steady && $urandom_range(0, 99) < 9) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	// mostly ticks so run and pause intervals actually run out
	task automatic send_random();
		int r;
		logic [1:0] kind;
		r = $urandom_range(0, 99);
		if (r < 78)
			kind = mrps_pkg::KIND_TICK;
		else if (r < 88)
			kind = mrps_pkg::KIND_MODE;
		else if (r < 97)
			kind = mrps_pkg::KIND_DELAY;
		else
			kind = KIND_SPARE;
		send_cmd(kind, 1'($urandom_range(0, 1)));
	endtask

	// Stop offering, wait for every status beat, then let the two-stage pipe empty.
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all five registers, one per cycle; only called with the block idle
	task automatic load_regs(input logic [7:0] v0, v1, v2, v3, v4);
		logic [7:0] vals [5];
		logic [2:0] regs [5];
		vals = '{v0, v1, v2, v3, v4};
		regs = '{mrps_pkg::REG_RUN_TICKS, mrps_pkg::REG_PAUSE_0, mrps_pkg::REG_PAUSE_1,
		         mrps_pkg::REG_PAUSE_2, mrps_pkg::REG_PAUSE_3};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			board.write_reg(regs[i], vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short intervals so each case shows up within a few beats.
		// pause_3 = 1 lets a delay press shorten a pause below the count already reached.
		load_regs(8'd1, 8'd1, 8'd2, 8'd3, 8'd1);
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);   // stopped, timer off
		send_cmd(KIND_SPARE, 1'b0);            // unused kind
		send_cmd(mrps_pkg::KIND_DELAY, 1'b0);  // delay press while stopped keeps timer off
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);
		send_cmd(mrps_pkg::KIND_MODE, 1'b0);   // right
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);   // run ends, pause of 2
		send_cmd(mrps_pkg::KIND_DELAY, 1'b0);  // pause becomes 3, count kept
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);
		send_cmd(mrps_pkg::KIND_DELAY, 1'b0);  // pause becomes 1, count already past it
		send_cmd(mrps_pkg::KIND_TICK, 1'b0);   // expires at once
		send_cmd(mrps_pkg::KIND_MODE, 1'b0);   // left
		send_cmd(mrps_pkg::KIND_MODE, 1'b1);   // ch1 right
		send_cmd(mrps_pkg::KIND_MODE, 1'b1);   // ch1 left
		send_cmd(mrps_pkg::KIND_MODE, 1'b1);   // ch1 alternating
		send_cmd(mrps_pkg::KIND_TICK, 1'b1);   // run ends
		send_cmd(mrps_pkg::KIND_TICK, 1'b1);   // pause of PAUSE_0_RST runs on, ch1 had no delay press
		send_cmd(mrps_pkg::KIND_TICK, 1'b1);
		send_cmd(mrps_pkg::KIND_TICK, 1'b1);   // pause still runs, direction stays right
		send_cmd(mrps_pkg::KIND_MODE, 1'b1);   // stop keeps direction
		send_cmd(mrps_pkg::KIND_MODE, 1'b0);   // ch0 alternating
		send_cmd(mrps_pkg::KIND_MODE, 1'b0);   // ch0 stop
		send_cmd(KIND_SPARE, 1'b1);
		send_cmd(mrps_pkg::KIND_DELAY, 1'b1);
		settle();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_regs(mrps_pkg::RUN_TICKS_RST, mrps_pkg::PAUSE_0_RST,
				             mrps_pkg::PAUSE_1_RST, mrps_pkg::PAUSE_2_RST,
				             mrps_pkg::PAUSE_3_RST);
				1: load_regs(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
				2: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				3: load_regs(8'd0, 8'd3, 8'd0, 8'd2, 8'd0);  // zero stalls the timer
				4: load_regs(8'd1, 8'd255, 8'd1, 8'd255, 8'd1);
				default: load_regs(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
				                   8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
				                   8'($urandom_range(1, 8)));
			endcase
			if (ph == 1)
				hold_req = 1'b1;
			if (ph == 5)
				steady = 1'b1;
			if (ph == 2) begin
				// block is idle here, so the predicted mode is exact: land ch0 in a
				// running mode, then tick through a full 255-tick run into the pause
				if (board.sel_mode[0] == mrps_pkg::MODE_ALT)
					send_cmd(mrps_pkg::KIND_MODE, 1'b0);
				send_cmd(mrps_pkg::KIND_MODE, 1'b0);
				repeat (256) send_cmd(mrps_pkg::KIND_TICK, 1'b0);
			end
			repeat ((ph == 2) ? 40 : 130) send_random();
			settle();
			steady = 1'b0;
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d commands under %0d register settings,", board.n_cmds,
		         n_settings);
		$display("  %0d status beats compared, %0d with an interval expiry.",
		         board.n_checked, board.n_expired);
		if (board.errors == 0 && board.waiting() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mrps_pkg.sv
rtl/core/motor_run_pause_sequencer.sv
dv/tb_motor_run_pause_sequencer.sv
